// ----- rtl/optm_pkg.sv -----
// optm_pkg: shared types and constants of the outer-product tile mac
// holds tile geometry, accumulator format and the lane control word
// no dependencies
package optm_pkg;

	localparam int TILE_ROWS = 4;
	localparam int TILE_COLS = 4;
	localparam int CELLS     = TILE_ROWS * TILE_COLS;
	localparam int ROW_W     = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
	localparam int COL_W     = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;

	localparam int ACC_W = 48;

	typedef logic signed [ACC_W-1:0] acc_t;

	localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// per-cycle control shared by all mac lanes
	typedef struct packed {
		logic mul_en;
		logic acc_en;
		logic clear;
	} lane_ctrl_t;

endpackage

// ----- rtl/outer_product_tile_mac_core.sv -----
// outer_product_tile_mac_core: 4x4 outer-product matrix-multiply tile engine
// depends on optm_pkg, optm_mac_lane, optm_drain
//
//   channel | handshake          | word
//   --------+--------------------+------------------------------------------------
//   in      | in_valid/in_stall  | a_elem0..3, b_elem0..3, final_step
//   out     | out_valid/out_stall| tile_row, tile_col, dot_sum, tile_done
//
// one depth step is accepted every cycle unless in_stall is raised; 16 mac lanes run in parallel
// stage 1 registers operands, stage 2 holds products, stage 3 accumulates
// a final step passes the operand and product stages into the result buffer,
// and its 16 words leave one per cycle while out_stall is low, overlapping the next tile's steps
// a final step waits in stage 2 while the previous tile still drains, so tiles
// shorter than 16 steps are paced by the result port
// reset clears pipeline valids, accumulators and the result buffer state
module outer_product_tile_mac_core
	import optm_pkg::*;
#(
	parameter int DATA_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] a_elem0,
	input  logic signed [DATA_WIDTH-1:0] a_elem1,
	input  logic signed [DATA_WIDTH-1:0] a_elem2,
	input  logic signed [DATA_WIDTH-1:0] a_elem3,
	input  logic signed [DATA_WIDTH-1:0] b_elem0,
	input  logic signed [DATA_WIDTH-1:0] b_elem1,
	input  logic signed [DATA_WIDTH-1:0] b_elem2,
	input  logic signed [DATA_WIDTH-1:0] b_elem3,
	input  logic                         final_step,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [1:0]                   tile_row,
	output logic [1:0]                   tile_col,
	output logic signed [ACC_W-1:0]      dot_sum,
	output logic                         tile_done
);

	logic signed [DATA_WIDTH-1:0] a_in [TILE_ROWS];
	logic signed [DATA_WIDTH-1:0] b_in [TILE_COLS];
	logic signed [DATA_WIDTH-1:0] a_s1 [TILE_ROWS];
	logic signed [DATA_WIDTH-1:0] b_s1 [TILE_COLS];
	logic       vld_s1, fin_s1;
	logic       vld_s2, fin_s2;
	logic       stall_s1, stall_s2;
	logic       adv_s1, adv_s2;
	logic       in_take;
	logic       drain_free;
	lane_ctrl_t ctrl;
	acc_t       sums [CELLS];

	assign a_in[0] = a_elem0;
	assign a_in[1] = a_elem1;
	assign a_in[2] = a_elem2;
	assign a_in[3] = a_elem3;
	assign b_in[0] = b_elem0;
	assign b_in[1] = b_elem1;
	assign b_in[2] = b_elem2;
	assign b_in[3] = b_elem3;

	// only a final step can block: it needs the result buffer free
	assign stall_s2 = vld_s2 && fin_s2 && !drain_free;
	assign adv_s2   = vld_s2 && !stall_s2;
	assign stall_s1 = vld_s2 && stall_s2;
	assign adv_s1   = vld_s1 && !stall_s1;
	assign in_stall = vld_s1 && stall_s1;
	assign in_take  = in_valid && !in_stall;

	assign ctrl.mul_en = adv_s1;
	assign ctrl.acc_en = adv_s2;
	assign ctrl.clear  = fin_s2;

	// operand stage
	always_ff @(posedge clk) begin
		if (in_take) begin
			a_s1   <= a_in;
			b_s1   <= b_in;
			fin_s1 <= final_step;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			fin_s2 <= fin_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				vld_s1 <= 1'b1;
			end else if (adv_s1) begin
				vld_s1 <= 1'b0;
			end
			if (adv_s1) begin
				vld_s2 <= 1'b1;
			end else if (adv_s2) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// one lane per tile cell, indexed row-major
	for (genvar r = 0; r < TILE_ROWS; r++) begin : g_row
		for (genvar c = 0; c < TILE_COLS; c++) begin : g_col
			optm_mac_lane #(
				.DATA_WIDTH(DATA_WIDTH)
			) u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.a       (a_s1[r]),
				.b       (b_s1[c]),
				.sum_next(sums[r*TILE_COLS+c])
			);
		end
	end

	// the buffer captures the sums that include the final step
	optm_drain u_drain (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (adv_s2 && fin_s2),
		.sums     (sums),
		.free     (drain_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tile_row (tile_row),
		.tile_col (tile_col),
		.dot_sum  (dot_sum),
		.tile_done(tile_done)
	);

endmodule

// ----- rtl/optm_mac_lane.sv -----
// optm_mac_lane: one tile cell, registered multiply then saturating accumulate
// depends on optm_pkg
module optm_mac_lane
	import optm_pkg::*;
#(
	parameter int DATA_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lane_ctrl_t                   ctrl,
	input  logic signed [DATA_WIDTH-1:0] a,
	input  logic signed [DATA_WIDTH-1:0] b,
	output acc_t                         sum_next
);

	localparam int PROD_W = 2 * DATA_WIDTH;
	localparam int SUM_W  = ACC_W + 1;

	logic signed [PROD_W-1:0] prod_s2;
	acc_t                     acc_q;
	logic signed [SUM_W-1:0]  sum_wide;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s2 <= a * b;
		end
	end

	// one extra bit catches overflow of the 48-bit range
	assign sum_wide = SUM_W'(acc_q) + SUM_W'(prod_s2);

	always_comb begin
		if (sum_wide[SUM_W-1] != sum_wide[SUM_W-2]) begin
			sum_next = sum_wide[SUM_W-1] ? ACC_MIN : ACC_MAX;
		end else begin
			sum_next = sum_wide[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= ctrl.clear ? '0 : sum_next;
		end
	end

endmodule

// ----- rtl/optm_drain.sv -----
// optm_drain: merges the lane sums into one result stream, row-major
// depends on optm_pkg
module optm_drain
	import optm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  acc_t       sums [CELLS],
	output logic       free,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] tile_row,
	output logic [1:0] tile_col,
	output acc_t       dot_sum,
	output logic       tile_done
);

	acc_t             buf_q [CELLS];
	logic             busy_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             take;
	logic             last;

	assign last      = (row_q == ROW_W'(TILE_ROWS - 1)) && (col_q == COL_W'(TILE_COLS - 1));
	assign take      = busy_q && !out_stall;
	assign free      = !busy_q || (take && last);
	assign out_valid = busy_q;
	assign tile_row  = 2'(row_q);
	assign tile_col  = 2'(col_q);
	assign dot_sum   = buf_q[0];
	assign tile_done = last;

	// buffer shifts toward entry 0 as words leave
	always_ff @(posedge clk) begin
		if (load && free) begin
			buf_q <= sums;
		end else if (take) begin
			for (int k = 0; k < CELLS - 1; k++) begin
				buf_q[k] <= buf_q[k+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			row_q  <= '0;
			col_q  <= '0;
		end else if (load && free) begin
			busy_q <= 1'b1;
			row_q  <= '0;
			col_q  <= '0;
		end else if (take) begin
			if (last) begin
				busy_q <= 1'b0;
				row_q  <= '0;
				col_q  <= '0;
			end else if (col_q == COL_W'(TILE_COLS - 1)) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

// ----- rtl/optm_checker.sv -----
// optm_checker: port-level checks on the result stream of the tile engine
// depends on optm_pkg; bound to outer_product_tile_mac_core
module optm_checker
	import optm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] tile_row,
	input logic [1:0] tile_col,
	input acc_t       dot_sum,
	input logic       tile_done
);

	// the last word of a tile is the bottom-right cell
	a_done_cell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tile_done |-> tile_row == 2'd3 && tile_col == 2'd3)
		else $error("tile_done away from last cell");

	// a new burst starts at the top-left cell
	a_start_cell: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> tile_row == 2'd0 && tile_col == 2'd0)
		else $error("burst does not start at cell zero");

	// within a row the next word follows at once, one column on
	a_next_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !tile_done && tile_col != 2'd3
		|=> out_valid && tile_row == $past(tile_row) && tile_col == $past(tile_col) + 2'd1)
		else $error("column sequence broken");

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dot_sum) && $stable(tile_done))
		else $error("stalled word changed");

endmodule

bind outer_product_tile_mac_core optm_checker u_optm_checker (.*);

// ----- sim/tb.sv -----
// tb: self-checking testbench for outer_product_tile_mac_core
// holds a tile-sum scoreboard class, the step and output drivers and the test sequence
// depends on optm_pkg and rtl/outer_product_tile_mac_core.sv
module tb;
	import optm_pkg::*;

	localparam int DW         = 16;
	localparam int DEEP_STEPS = 12;         // steady run of large corner products
	localparam int RAND_STEPS = 390;
	localparam int DRAIN_SLACK = 40;
	localparam longint RUN_LIMIT = 15_000_000;

	typedef logic signed [DW-1:0] elem_t;

	// one depth step: a column slice of A and a row slice of B
	typedef struct packed {
		elem_t [TILE_ROWS-1:0] a;
		elem_t [TILE_COLS-1:0] b;
		logic                  last;
	} step_t;

	typedef struct packed {
		logic [1:0] row;
		logic [1:0] col;
		acc_t       sum;
		logic       done;
	} tile_sum_t;

	// running tile sums and the words still owed by the block
	class tile_scoreboard;
		acc_t      acc [CELLS];
		tile_sum_t sums_due [$];
		int        bad_words;

		function new();
			foreach (acc[k])
				acc[k] = '0;
			bad_words = 0;
		endfunction

		function void note_bad(string msg);
			bad_words++;
			if (bad_words <= 10)
				$display("mismatch: %s", msg);
		endfunction

		// saturating outer-product accumulate; a last step flushes the tile row-major
		function void take_step(step_t s);
			logic signed [2*DW-1:0] prod;
			logic signed [ACC_W:0]  wide;
			int                     k;
			for (int r = 0; r < TILE_ROWS; r++) begin
				for (int c = 0; c < TILE_COLS; c++) begin
					k = r * TILE_COLS + c;
					prod = $signed(s.a[r]) * $signed(s.b[c]);
					wide = acc[k] + prod;
					if (wide > ACC_MAX)
						acc[k] = ACC_MAX;
					else if (wide < ACC_MIN)
						acc[k] = ACC_MIN;
					else
						acc[k] = wide[ACC_W-1:0];
				end
			end
			if (s.last) begin
				for (int r = 0; r < TILE_ROWS; r++) begin
					for (int c = 0; c < TILE_COLS; c++) begin
						k = r * TILE_COLS + c;
						sums_due.push_back('{row: r[1:0], col: c[1:0], sum: acc[k],
							done: (k == CELLS - 1)});
						acc[k] = '0;
					end
				end
			end
		endfunction

		function void check_sum(logic [1:0] row, logic [1:0] col, acc_t sum, logic done);
			tile_sum_t want;
			if (sums_due.size() == 0) begin
				note_bad($sformatf("unexpected word row %0d col %0d sum %0d done %0b",
					row, col, sum, done));
				return;
			end
			want = sums_due.pop_front();
			if (row !== want.row)
				note_bad($sformatf("tile_row expected %0d got %0d", want.row, row));
			if (col !== want.col)
				note_bad($sformatf("tile_col expected %0d got %0d", want.col, col));
			if (sum !== want.sum)
				note_bad($sformatf("dot_sum at (%0d,%0d) expected %0d got %0d",
					want.row, want.col, want.sum, sum));
			if (done !== want.done)
				note_bad($sformatf("tile_done at (%0d,%0d) expected %0b got %0b",
					want.row, want.col, want.done, done));
		endfunction

		function bit clean();
			return bad_words == 0 && sums_due.size() == 0;
		endfunction
	endclass

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	elem_t a_elem0 = '0, a_elem1 = '0, a_elem2 = '0, a_elem3 = '0;
	elem_t b_elem0 = '0, b_elem1 = '0, b_elem2 = '0, b_elem3 = '0;
	logic  final_step = 1'b0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	logic [1:0] tile_row;
	logic [1:0] tile_col;
	acc_t  dot_sum;
	logic  tile_done;

	tile_scoreboard sb;

	outer_product_tile_mac_core #(
		.DATA_WIDTH(DW)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.a_elem0   (a_elem0),
		.a_elem1   (a_elem1),
		.a_elem2   (a_elem2),
		.a_elem3   (a_elem3),
		.b_elem0   (b_elem0),
		.b_elem1   (b_elem1),
		.b_elem2   (b_elem2),
		.b_elem3   (b_elem3),
		.final_step(final_step),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.tile_row  (tile_row),
		.tile_col  (tile_col),
		.dot_sum   (dot_sum),
		.tile_done (tile_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly back-to-back, sometimes a short gap, rarely a long hole
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// operand mix leans on the corners of the Q2.14 range
	function automatic elem_t rand_elem();
		case ($urandom_range(0, 9))
			0: return elem_t'(16'sh8000);
			1: return elem_t'(16'sh7fff);
			2: return '0;
			3: return '1;
			4: return elem_t'($urandom_range(0, 63)) - elem_t'(32);
			default: return elem_t'($urandom);
		endcase
	endfunction

	function automatic step_t rand_step(bit last);
		step_t s;
		for (int i = 0; i < TILE_ROWS; i++)
			s.a[i] = rand_elem();
		for (int i = 0; i < TILE_COLS; i++)
			s.b[i] = rand_elem();
		s.last = last;
		return s;
	endfunction

	function automatic step_t mk_step(elem_t a0, elem_t a1, elem_t a2, elem_t a3,
		elem_t b0, elem_t b1, elem_t b2, elem_t b3, bit last);
		step_t s;
		s.a = {a3, a2, a1, a0};
		s.b = {b3, b2, b1, b0};
		s.last = last;
		return s;
	endfunction

	// present one word, hold it until taken, then record it as accepted
	task automatic send_step(step_t s, bit quiet);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		a_elem0    <= s.a[0];
		a_elem1    <= s.a[1];
		a_elem2    <= s.a[2];
		a_elem3    <= s.a[3];
		b_elem0    <= s.b[0];
		b_elem1    <= s.b[1];
		b_elem2    <= s.b[2];
		b_elem3    <= s.b[3];
		final_step <= s.last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.take_step(s);
	endtask

	task automatic send_tile(int depth, bit quiet);
		for (int i = 0; i < depth; i++)
			send_step(rand_step(i == depth - 1), quiet);
	endtask

	task automatic wait_drained();
		while (sb.sums_due.size() != 0)
			@(posedge clk);
	endtask

	// result side: random stall bursts between stall-free stretches, mostly short, sometimes long
	initial begin
		int busy;
		int free;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			busy = pick_gap();
			if (busy > 0) begin
				out_stall <= 1'b1;
				repeat (busy) @(posedge clk);
			end
			free = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 8);
			out_stall <= 1'b0;
			repeat (free) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_sum(tile_row, tile_col, dot_sum, tile_done);
	end

	initial begin
		#RUN_LIMIT;
		$display("outer_product_tile_mac_core regression: fail");
		$finish;
	end

	initial begin
		int  sent;
		int  tiles;
		int  depth;
		bit  quiet;
		bit  long_done;
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero tile, corner products, a short mixed tile, a zero-padded tile
		send_step(mk_step('0, '0, '0, '0, '0, '0, '0, '0, 1'b1), 1'b0);
		send_step(mk_step(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
			-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b1), 1'b0);
		send_step(mk_step(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
			-16'sd32768, 16'sd32767, -16'sd1, 16'sd1, 1'b1), 1'b0);
		send_step(mk_step(16'sd1, 16'sd2, 16'sd3, 16'sd4,
			16'sd16, 16'sd32, 16'sd48, 16'sd64, 1'b0), 1'b0);
		send_step(mk_step(-16'sd5, 16'sd16384, -16'sd16384, 16'sd7,
			16'sd100, -16'sd200, 16'sd300, -16'sd400, 1'b0), 1'b0);
		send_step(mk_step(16'sd32767, 16'sd32767, -16'sd1, 16'sd0,
			16'sd32767, -16'sd32768, 16'sd12345, -16'sd1, 1'b0), 1'b0);
		send_step(mk_step(16'sh5555, -16'sh2aab, 16'sh0f0f, -16'sh0f10,
			16'sh3333, -16'sh3334, 16'sh00ff, -16'sh0100, 1'b1), 1'b0);
		// partial tile padded with zeros in the last row and column
		send_step(mk_step(16'sd9, -16'sd9, 16'sd900, 16'sd0,
			16'sd7, 16'sd70, -16'sd700, 16'sd0, 1'b0), 1'b0);
		send_step(mk_step(-16'sd32768, 16'sd32767, 16'sd1, 16'sd0,
			16'sd32767, 16'sd1, -16'sd32768, 16'sd0, 1'b1), 1'b0);
		// single-step tiles back to back push on the result port pacing
		for (int i = 0; i < 4; i++)
			send_step(rand_step(1'b1), 1'b1);
		for (int i = 0; i < 6; i++)
			send_step(rand_step(i == 5), 1'b0);
		in_valid <= 1'b0;
		wait_drained();

		// one tile of repeated corner products, large sums of both signs,
		// then a short mixed tail closes it
		for (int i = 0; i < DEEP_STEPS; i++)
			send_step(mk_step(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
				-16'sd32768, 16'sd32767, -16'sd32768, 16'sd0, 1'b0), 1'b1);
		for (int i = 0; i < 6; i++)
			send_step(mk_step(16'sd32767, -16'sd32768, 16'sd12, -16'sd12,
				-16'sd32768, 16'sd32767, 16'sd5, rand_elem(), i == 5), 1'b0);

		// random tiles, mostly short, one of 257 to 280 steps
		sent = 0;
		tiles = 0;
		long_done = 1'b0;
		while (sent < RAND_STEPS) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5: depth = 1;
				6, 7, 8, 9, 10, 11, 12, 13, 14, 15: depth = $urandom_range(2, 8);
				default: depth = $urandom_range(9, 40);
			endcase
			if (!long_done && tiles == 10) begin
				depth = $urandom_range(257, 280);
				long_done = 1'b1;
			end
			// sender holds off until the block has nothing left to emit
			if (tiles == 20) begin
				in_valid <= 1'b0;
				wait_drained();
			end
			quiet = ($urandom_range(0, 3) == 0);
			send_tile(depth, quiet);
			sent += depth;
			tiles++;
		end
		in_valid <= 1'b0;

		wait_drained();
		repeat (DRAIN_SLACK) @(posedge clk);
		if (sb.clean())
			$display("outer_product_tile_mac_core regression: pass");
		else
			$display("outer_product_tile_mac_core regression: fail");
		$finish;
	end

endmodule
